// File: hdl/encoder_setpoint_adjuster_core_macros.svh
// ----------------------------------------------------------------------------
// encoder setpoint adjuster assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ENCODER_SETPOINT_ADJUSTER_CORE_MACROS_SVH
`define ENCODER_SETPOINT_ADJUSTER_CORE_MACROS_SVH

// same-cycle implication
`define ESA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/esa_pkg.sv
// ----------------------------------------------------------------------------
// encoder setpoint adjuster package
// widths, register indexes, reset values and step sizes
// ----------------------------------------------------------------------------
package esa_pkg;

    // pulse counter width (8 to 32)
    localparam int COUNT_BITS = 16;

    localparam int TIME_W  = 17;
    localparam int SPEED_W = 16;
    localparam int RATE_W  = 18;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 18;

    // width that holds count * 3 and the rate ceiling
    localparam int PROD_W = (COUNT_BITS + 2 > RATE_W) ? COUNT_BITS + 2 : RATE_W;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_TIME_MAX  = 3'd0,
        REG_TIME_MIN  = 3'd1,
        REG_SPEED_MAX = 3'd2,
        REG_SPEED_MIN = 3'd3,
        REG_FAST_THR  = 3'd4
    } t_cfg_reg;

    // reset values of the configuration registers
    localparam logic [TIME_W-1:0]  TIME_MAX_RST  = TIME_W'(86400);
    localparam logic [TIME_W-1:0]  TIME_MIN_RST  = TIME_W'(60);
    localparam logic [SPEED_W-1:0] SPEED_MAX_RST = SPEED_W'(3000);
    localparam logic [SPEED_W-1:0] SPEED_MIN_RST = SPEED_W'(100);
    localparam logic [RATE_W-1:0]  FAST_THR_RST  = RATE_W'(60);

    // step sizes and limits
    localparam logic [TIME_W-1:0]  TIME_STEP_SLOW  = TIME_W'(60);
    localparam logic [TIME_W-1:0]  TIME_STEP_FAST  = TIME_W'(600);
    localparam logic [SPEED_W-1:0] SPEED_STEP_SLOW = SPEED_W'(10);
    localparam logic [SPEED_W-1:0] SPEED_STEP_FAST = SPEED_W'(50);
    localparam logic [TIME_W-1:0]  TIME_ENABLE_MIN = TIME_W'(60);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PROD_W-1:0]     RATE_MAX  = PROD_W'({RATE_W{1'b1}});

    // item kind on the input tuser
    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

endpackage

// File: hdl/encoder_setpoint_adjuster_core.sv
// an accepted input word moves from the input register through the update logic into the
// result register; throughput: one word per cycle while the result side is not stalled
// a stalled result word holds a full input register, so tready drops until the result moves
// reset (synchronous, active low) zeroes setpoints, pulse counts and rates,
// loads the default limits and empties both registers
// ----------------------------------------------------------------------------
// encoder setpoint adjuster core
// two knobs step a time and a speed setpoint, step size from measured knob rate
// ----------------------------------------------------------------------------
`include "encoder_setpoint_adjuster_core_macros.svh"

module encoder_setpoint_adjuster_core
    import esa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_DW-1:0]     i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // b_level, motor_stopped, zero fill
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // operation, knob
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // time_setpoint, speed_setpoint,
                                                  // time_enabled, time_blink_restart,
                                                  // speed_blink_restart, knob_turned,
                                                  // zero fill
);

    // configuration registers
    logic [TIME_W-1:0]  r_time_max, r_time_min;
    logic [SPEED_W-1:0] r_speed_max, r_speed_min;
    logic [RATE_W-1:0]  r_fast_thr;

    // block state
    logic [TIME_W-1:0]     r_time_val, n_time_val;
    logic [SPEED_W-1:0]    r_speed_val, n_speed_val;
    logic [COUNT_BITS-1:0] r_pulse_cnt [2];
    logic [COUNT_BITS-1:0] n_pulse_cnt [2];
    logic [RATE_W-1:0]     r_knob_rate [2];
    logic [RATE_W-1:0]     n_knob_rate [2];

    // input register
    logic r_in_valid;
    t_op  r_in_op;
    logic r_in_knob, r_in_dec, r_in_stopped;

    // result register
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_time;
    logic [SPEED_W-1:0]  r_out_speed;
    logic                r_out_ten, r_out_tblink, r_out_sblink;
    logic [1:0]          r_out_turned;

    logic out_free, adv;
    logic fast;
    logic tblink, sblink;
    logic [1:0] turned;
    logic [TIME_W:0]    time_sum;
    logic [TIME_W-1:0]  time_step, time_diff;
    logic               time_borrow;
    logic [SPEED_W:0]   speed_sum;
    logic [SPEED_W-1:0] speed_step, speed_diff;
    logic               speed_borrow;
    logic [PROD_W-1:0]  prod [2];

    // handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_max  <= TIME_MAX_RST;
            r_time_min  <= TIME_MIN_RST;
            r_speed_max <= SPEED_MAX_RST;
            r_speed_min <= SPEED_MIN_RST;
            r_fast_thr  <= FAST_THR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_TIME_MAX:  r_time_max  <= i_cfg_wdata[TIME_W-1:0];
                REG_TIME_MIN:  r_time_min  <= i_cfg_wdata[TIME_W-1:0];
                REG_SPEED_MAX: r_speed_max <= i_cfg_wdata[SPEED_W-1:0];
                REG_SPEED_MIN: r_speed_min <= i_cfg_wdata[SPEED_W-1:0];
                REG_FAST_THR:  r_fast_thr  <= i_cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op      <= t_op'(s_axis_tuser[0]);
            r_in_knob    <= s_axis_tuser[1];
            r_in_dec     <= s_axis_tdata[0];
            r_in_stopped <= s_axis_tdata[1];
        end
    end

    // step arithmetic
    always_comb begin
        fast       = r_knob_rate[r_in_knob] >= r_fast_thr;
        time_step  = fast ? TIME_STEP_FAST : TIME_STEP_SLOW;
        speed_step = fast ? SPEED_STEP_FAST : SPEED_STEP_SLOW;

        time_sum     = {1'b0, r_time_val} + {1'b0, time_step};
        time_borrow  = r_time_val < time_step;
        time_diff    = r_time_val - time_step;
        speed_sum    = {1'b0, r_speed_val} + {1'b0, speed_step};
        speed_borrow = r_speed_val < speed_step;
        speed_diff   = r_speed_val - speed_step;

        for (int i = 0; i < 2; i++) begin
            prod[i] = PROD_W'({r_pulse_cnt[i], 1'b0}) + PROD_W'(r_pulse_cnt[i]);
        end
    end

    // next state and result flags
    always_comb begin
        n_time_val  = r_time_val;
        n_speed_val = r_speed_val;
        n_pulse_cnt = r_pulse_cnt;
        n_knob_rate = r_knob_rate;
        tblink      = 1'b0;
        sblink      = 1'b0;
        turned      = 2'b00;

        case (r_in_op)
            OP_TICK: begin
                for (int i = 0; i < 2; i++) begin
                    n_knob_rate[i] = (prod[i] > RATE_MAX) ? RATE_MAX[RATE_W-1:0]
                                                          : prod[i][RATE_W-1:0];
                    n_pulse_cnt[i] = '0;
                end
            end
            OP_EDGE: begin
                if (r_pulse_cnt[r_in_knob] != COUNT_MAX) begin
                    n_pulse_cnt[r_in_knob] = r_pulse_cnt[r_in_knob] + COUNT_BITS'(1);
                end
                if (!r_in_stopped) begin
                    if (!r_in_knob) begin
                        if (!r_in_dec) begin
                            n_time_val = (time_sum > {1'b0, r_time_max}) ? r_time_max
                                                                         : time_sum[TIME_W-1:0];
                        end else begin
                            n_time_val = (time_borrow || time_diff < r_time_min) ? '0
                                                                                 : time_diff;
                        end
                        tblink = 1'b1;
                        turned = 2'b01;
                    end else begin
                        if (!r_in_dec) begin
                            n_speed_val = (speed_sum > {1'b0, r_speed_max})
                                        ? r_speed_max : speed_sum[SPEED_W-1:0];
                        end else begin
                            n_speed_val = (speed_borrow || speed_diff < r_speed_min)
                                        ? r_speed_min : speed_diff;
                        end
                        sblink = 1'b1;
                        turned = 2'b10;
                    end
                end
            end
            default: ;
        endcase
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_val  <= '0;
            r_speed_val <= '0;
            r_pulse_cnt <= '{default: '0};
            r_knob_rate <= '{default: '0};
        end else if (adv) begin
            r_time_val  <= n_time_val;
            r_speed_val <= n_speed_val;
            r_pulse_cnt <= n_pulse_cnt;
            r_knob_rate <= n_knob_rate;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_time   <= n_time_val;
            r_out_speed  <= n_speed_val;
            r_out_ten    <= n_time_val >= TIME_ENABLE_MIN;
            r_out_tblink <= tblink;
            r_out_sblink <= sblink;
            r_out_turned <= turned;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_turned, r_out_sblink, r_out_tblink, r_out_ten,
                            r_out_speed, r_out_time};

    // checks
    `ESA_ASSERT_IMP(a_turned_onehot0, r_out_valid, $onehot0(r_out_turned),
        "both knobs flagged as turned")
    `ESA_ASSERT_IMP(a_blink_matches_turned, r_out_valid,
        r_out_tblink == r_out_turned[0] && r_out_sblink == r_out_turned[1],
        "blink restart disagrees with knob_turned")
    `ESA_ASSERT_NXT(a_tick_clears_counts, adv && r_in_op == OP_TICK,
        r_pulse_cnt[0] == '0 && r_pulse_cnt[1] == '0, "window tick left a pulse count")
    `ESA_ASSERT_NXT(a_stall_keeps_input, r_in_valid && r_out_valid && !m_axis_tready,
        r_in_valid, "input word lost while result stalled")

endmodule

// File: tb/tb_encoder_setpoint_adjuster_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder setpoint adjuster core testbench
// knob edges and rate window ticks go in as bursts with random gaps (none when
// gapless), while the result side stalls on a pattern of its own; every result
// word is predicted from a local copy of setpoints, counts, rates and limits and
// compared field by field; limits change between phases, extremes included
// ----------------------------------------------------------------------------
module tb_encoder_setpoint_adjuster_core;
    import esa_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 190;
    localparam int DRAIN_TAIL  = 8;

    localparam int ENABLE_LEVEL   = 60;
    localparam int T_STEP_SMALL   = 60;
    localparam int T_STEP_LARGE   = 600;
    localparam int S_STEP_SMALL   = 10;
    localparam int S_STEP_LARGE   = 50;
    localparam logic [1:0] TURN_NONE  = 2'b00;
    localparam logic [1:0] TURN_TIME  = 2'b01;
    localparam logic [1:0] TURN_SPEED = 2'b10;

    localparam logic [RATE_W-1:0]     RATE_CEIL  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [TIME_W-1:0]  time_sp;
        logic [SPEED_W-1:0] speed_sp;
        logic               time_en;
        logic               time_blink;
        logic               speed_blink;
        logic [1:0]         turned;
    } t_setpoint_word;

    typedef struct packed {
        t_op            op;
        logic           knob;
        logic           down;
        logic           stopped;
        logic           typed;
        t_setpoint_word want;
    } t_dir_row;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_CHOKE
    } t_rx_mode;

    // directed opening at reset limits; typed words where the result is obvious
    localparam int DIR_ROWS_N = 11;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // tick straight after reset: everything zero
        '{OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1, '{17'd0, 16'd0, 1'b0, 1'b0, 1'b0, TURN_NONE}},
        // time up from zero with small step
        '{OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b1, '{17'd60, 16'd0, 1'b1, 1'b1, 1'b0, TURN_TIME}},
        // time down lands below the minimum: back to zero
        '{OP_EDGE, 1'b0, 1'b1, 1'b0, 1'b1, '{17'd0, 16'd0, 1'b0, 1'b1, 1'b0, TURN_TIME}},
        // speed down from zero goes negative: held at the minimum
        '{OP_EDGE, 1'b1, 1'b1, 1'b0, 1'b1, '{17'd0, 16'd100, 1'b0, 1'b0, 1'b1, TURN_SPEED}},
        '{OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b1, '{17'd0, 16'd110, 1'b0, 1'b0, 1'b1, TURN_SPEED}},
        // motor stopped: counted only
        '{OP_EDGE, 1'b0, 1'b0, 1'b1, 1'b1, '{17'd0, 16'd110, 1'b0, 1'b0, 1'b0, TURN_NONE}},
        '{OP_EDGE, 1'b1, 1'b1, 1'b1, 1'b1, '{17'd0, 16'd110, 1'b0, 1'b0, 1'b0, TURN_NONE}},
        // tick with the edge-only bits set: they are ignored
        '{OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, '{17'd0, 16'd110, 1'b0, 1'b0, 1'b0, TURN_NONE}},
        '{OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, '0},
        '{OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, '0}
    };

    // dut ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [CFG_DW-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // b_level, motor_stopped, zero fill
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // operation, knob
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // time_setpoint, speed_setpoint,
                                                // time_enabled, time_blink_restart,
                                                // speed_blink_restart, knob_turned,
                                                // zero fill

    // local copy of the block state and limits
    logic [TIME_W-1:0]     time_now;
    logic [SPEED_W-1:0]    speed_now;
    logic [COUNT_BITS-1:0] edge_cnt [2];
    logic [RATE_W-1:0]     knob_rate [2];
    logic [TIME_W-1:0]     lim_time_max;
    logic [TIME_W-1:0]     lim_time_min;
    logic [SPEED_W-1:0]    lim_speed_max;
    logic [SPEED_W-1:0]    lim_speed_min;
    logic [RATE_W-1:0]     fast_thr;

    t_setpoint_word pending_setpoints [$];
    int             fails      = 0;
    int             burst_left = 0;
    bit             gapless    = 1'b0;
    int             idle_cycles = 0;
    t_rx_mode       rx_mode    = RX_OPEN;
    int             rx_left    = 0;
    int             rx_tick    = 0;

    encoder_setpoint_adjuster_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // next setpoint word for one input word, advancing the local state
    function automatic t_setpoint_word advance_setpoints(t_op op, logic knob, logic down,
                                                         logic stopped);
        t_setpoint_word res;
        longint         acc;
        longint         prod;
        longint         step;
        logic           fast;
        res = '0;
        if (op == OP_TICK) begin
            for (int k = 0; k < 2; k++) begin
                prod = longint'(edge_cnt[k]) * 3;
                knob_rate[k] = (prod > longint'(RATE_CEIL)) ? RATE_CEIL : prod[RATE_W-1:0];
                edge_cnt[k] = '0;
            end
        end else begin
            if (edge_cnt[knob] != COUNT_FULL)
                edge_cnt[knob] = edge_cnt[knob] + COUNT_BITS'(1);
            if (!stopped) begin
                fast = knob_rate[knob] >= fast_thr;
                if (knob == 1'b0) begin
                    step = fast ? T_STEP_LARGE : T_STEP_SMALL;
                    acc  = longint'(time_now);
                    if (!down) begin
                        acc += step;
                        if (acc > longint'(lim_time_max))
                            acc = longint'(lim_time_max);
                    end else begin
                        acc -= step;
                        if (acc < longint'(lim_time_min))
                            acc = 0;
                    end
                    time_now       = acc[TIME_W-1:0];
                    res.time_blink = 1'b1;
                    res.turned     = TURN_TIME;
                end else begin
                    step = fast ? S_STEP_LARGE : S_STEP_SMALL;
                    acc  = longint'(speed_now);
                    if (!down) begin
                        acc += step;
                        if (acc > longint'(lim_speed_max))
                            acc = longint'(lim_speed_max);
                    end else begin
                        acc -= step;
                        if (acc < longint'(lim_speed_min))
                            acc = longint'(lim_speed_min);
                    end
                    speed_now       = acc[SPEED_W-1:0];
                    res.speed_blink = 1'b1;
                    res.turned      = TURN_SPEED;
                end
            end
        end
        res.time_sp  = time_now;
        res.speed_sp = speed_now;
        res.time_en  = int'(time_now) >= ENABLE_LEVEL;
        return res;
    endfunction

    task automatic flag_error(string msg);
        $display("%0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // one input word, held until taken; predicted at the accepting edge
    task automatic drive_word(t_op op, logic knob, logic down, logic stopped, logic typed,
                              t_setpoint_word want);
        t_setpoint_word pred;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {knob, op};
        s_axis_tdata  <= {{(IN_DATA_W-2){1'b0}}, stopped, down};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pred = advance_setpoints(op, knob, down, stopped);
        pending_setpoints.push_back(typed ? want : pred);
    endtask

    // sender bursts with random gaps unless the phase runs gapless
    task automatic paced_word(t_op op, logic knob, logic down, logic stopped, logic typed,
                              t_setpoint_word want, int max_burst);
        int gap;
        if (burst_left == 0) begin
            if (!gapless) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, max_burst);
        end
        burst_left--;
        drive_word(op, knob, down, stopped, typed, want);
    endtask

    task automatic random_word(int tick_pct, int up_pct, int stop_pct);
        t_op  op;
        logic knob;
        logic down;
        logic stopped;
        op      = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_EDGE;
        knob    = 1'($urandom_range(0, 1));
        down    = $urandom_range(0, 99) >= up_pct;
        stopped = $urandom_range(0, 99) < stop_pct;
        paced_word(op, knob, down, stopped, 1'b0, '0, 24);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(t_cfg_reg idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_TIME_MAX:  lim_time_max  = val[TIME_W-1:0];
            REG_TIME_MIN:  lim_time_min  = val[TIME_W-1:0];
            REG_SPEED_MAX: lim_speed_max = val[SPEED_W-1:0];
            REG_SPEED_MIN: lim_speed_min = val[SPEED_W-1:0];
            REG_FAST_THR:  fast_thr      = val[RATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(logic [CFG_DW-1:0] tmax, logic [CFG_DW-1:0] tmin,
                                logic [CFG_DW-1:0] smax, logic [CFG_DW-1:0] smin,
                                logic [CFG_DW-1:0] thr);
        write_limit(REG_TIME_MAX, tmax);
        write_limit(REG_TIME_MIN, tmin);
        write_limit(REG_SPEED_MAX, smax);
        write_limit(REG_SPEED_MIN, smin);
        write_limit(REG_FAST_THR, thr);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // limit set for each random phase after the first, extremes among them
    task automatic phase_limits(int p);
        logic [CFG_DW-1:0] tmax;
        logic [CFG_DW-1:0] smax;
        case (p)
            1: apply_limits(CFG_DW'($urandom_range(0, 3000)), CFG_DW'($urandom_range(0, 1500)),
                            CFG_DW'($urandom_range(0, 800)), CFG_DW'($urandom_range(0, 400)),
                            CFG_DW'($urandom_range(0, 15)));
            2: apply_limits(CFG_DW'(86400), CFG_DW'(86400), CFG_DW'(65535), CFG_DW'(65535),
                            CFG_DW'(262143));
            3: apply_limits('0, '0, '0, '0, '0);
            4: apply_limits(CFG_DW'(86400), '0, CFG_DW'(65535), '0, '0);
            // raw full-width writes, truncated by the narrower registers
            5: apply_limits(CFG_DW'($urandom()), CFG_DW'($urandom()), CFG_DW'($urandom()),
                            CFG_DW'($urandom()), CFG_DW'($urandom_range(0, 40)));
            // minimum above maximum
            6: begin
                tmax = CFG_DW'($urandom_range(0, 2000));
                smax = CFG_DW'($urandom_range(0, 3000));
                apply_limits(tmax, tmax + CFG_DW'($urandom_range(1, 2000)),
                             smax, smax + CFG_DW'($urandom_range(1, 3000)),
                             CFG_DW'($urandom_range(0, 30)));
            end
            default: apply_limits(CFG_DW'($urandom_range(0, 86400)),
                                  CFG_DW'($urandom_range(0, 86400)),
                                  CFG_DW'($urandom_range(0, 65535)),
                                  CFG_DW'($urandom_range(0, 65535)),
                                  CFG_DW'($urandom_range(0, 90)));
        endcase
    endtask

    // receiver stall pattern, switching mode every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 300);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN: m_axis_tready <= 1'b1;
            RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB: m_axis_tready <= (rx_tick % 5) != 0;
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result word checker
    always @(posedge i_clk) begin : result_check
        t_setpoint_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_setpoints.size() == 0) begin
                flag_error($sformatf("result word with nothing expected: %h", m_axis_tdata));
            end else begin
                want = pending_setpoints.pop_front();
                check_field("time_setpoint", 32'(m_axis_tdata[0 +: TIME_W]), 32'(want.time_sp));
                check_field("speed_setpoint", 32'(m_axis_tdata[TIME_W +: SPEED_W]),
                            32'(want.speed_sp));
                check_field("time_enabled", 32'(m_axis_tdata[TIME_W+SPEED_W]),
                            32'(want.time_en));
                check_field("time_blink_restart", 32'(m_axis_tdata[TIME_W+SPEED_W+1]),
                            32'(want.time_blink));
                check_field("speed_blink_restart", 32'(m_axis_tdata[TIME_W+SPEED_W+2]),
                            32'(want.speed_blink));
                check_field("knob_turned", 32'(m_axis_tdata[TIME_W+SPEED_W+3 +: 2]),
                            32'(want.turned));
            end
        end
    end

    // watchdog on cycles with no word moving on either side and no configuration write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL encoder_setpoint_adjuster_core");
            $finish;
        end
    end

    initial begin
        int   tick_pct;
        int   up_pct;
        int   stop_pct;

        time_now      = '0;
        speed_now     = '0;
        edge_cnt      = '{default: '0};
        knob_rate     = '{default: '0};
        lim_time_max  = TIME_W'(86400);
        lim_time_min  = TIME_W'(60);
        lim_speed_max = SPEED_W'(3000);
        lim_speed_min = SPEED_W'(100);
        fast_thr      = RATE_W'(60);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        for (int r = 0; r < DIR_ROWS_N; r++)
            paced_word(DIR_ROWS[r].op, DIR_ROWS[r].knob, DIR_ROWS[r].down,
                       DIR_ROWS[r].stopped, DIR_ROWS[r].typed, DIR_ROWS[r].want, 4);

        // random phases, each under its own limits and traffic mix
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p != 0) begin
                drain_results();
                phase_limits(p);
            end
            gapless    = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            tick_pct   = $urandom_range(2, 15);
            up_pct     = $urandom_range(20, 85);
            stop_pct   = $urandom_range(5, 25);
            repeat (PHASE_WORDS) random_word(tick_pct, up_pct, stop_pct);
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fails == 0)
            $display("PASS encoder_setpoint_adjuster_core");
        else
            $display("FAIL encoder_setpoint_adjuster_core");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/esa_pkg.sv
hdl/encoder_setpoint_adjuster_core.sv
tb/tb_encoder_setpoint_adjuster_core.sv
